@@ rtl/core/signed_radix_to_text_defines.svh @@
// Assertion macros shared by the signed_radix_to_text RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef SIGNED_RADIX_TO_TEXT_DEFINES_SVH
`define SIGNED_RADIX_TO_TEXT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SRT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srt assertion failed");
`define SRT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srt assertion failed");
`else
`define SRT_ASSERT_IMP(label, ante, cons)
`define SRT_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ rtl/core/srt_pkg.sv @@
// Shared types and constants for the signed radix-to-text block.
// No dependencies.
package srt_pkg;

    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 2;
    localparam int COUNT_BITS     = 5;
    localparam int SYM_BITS       = 8;
    localparam int SYMBOL_SLOTS   = 16;
    localparam int DIGIT_BITS     = 4;
    // quotient bits resolved per divider cycle
    localparam int DIV_STEP_BITS  = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SYMBOL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [COUNT_BITS-1:0]    RESET_SYMBOL_COUNT = 5'd10;
    localparam logic [CFG_DATA_BITS-1:0] RESET_SYMBOLS_LOW  = 64'h3736353433323130;
    localparam logic [CFG_DATA_BITS-1:0] RESET_SYMBOLS_HIGH = 64'h0000000000003938;

    localparam logic [SYM_BITS-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_BITS-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_BITS-1:0] CHAR_NUL   = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } srt_state_t;

    typedef struct packed {
        logic load;
        logic go;
    } div_cmd_t;

    typedef struct packed {
        logic                  done;
        logic                  quot_zero;
        logic [DIGIT_BITS-1:0] rem;
    } div_stat_t;

endpackage

@@ rtl/core/signed_radix_to_text.sv @@
// Signed integer to text in a configurable radix. Raise start for one cycle while busy
// is low; characters then come out one per strobe, most significant first, with a
// leading '-' for negatives and last on the final one. There is no backpressure. An
// item is accepted, its alphabet is checked one symbol per cycle (each symbol compared
// against every later symbol in use), each digit is then produced by the shared
// 4-bit-per-cycle divider, and the characters are emitted one per cycle.
// A bad alphabet ends the item after the check with a single word flagged not ok.
`include "signed_radix_to_text_defines.svh"

module signed_radix_to_text import srt_pkg::*; #(
    parameter int MAX_SYMBOLS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,
    output logic                         strobe,
    output logic [SYM_BITS-1:0]          character,
    output logic                         last,
    output logic                         alphabet_ok
);

    localparam int ND_W = $clog2(VALUE_BITS + 1);

    srt_state_t              state_reg, state_next;
    logic [COUNT_BITS-1:0]   symbol_count_reg;
    logic [CFG_DATA_BITS-1:0] symbols_low_reg, symbols_high_reg;
    logic [DIGIT_BITS-1:0]   idx_reg, idx_next;
    logic                    sign_reg, sign_next;
    logic [ND_W-1:0]         nd_reg, nd_next;
    logic [DIGIT_BITS-1:0]   digit_reg [VALUE_BITS];
    logic                    push, pop;
    logic                    strobe_reg, strobe_next;
    logic [SYM_BITS-1:0]     character_reg, character_next;
    logic                    last_reg, last_next;
    logic                    ok_reg, ok_next;

    logic [SYM_BITS-1:0]     sym [SYMBOL_SLOTS];
    logic [SYM_BITS-1:0]     cur_sym;
    logic                    count_bad, sym_bad, idx_at_end;
    logic [VALUE_BITS-1:0]   mag;
    div_cmd_t                div_cmd;
    div_stat_t               div_stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= RESET_SYMBOL_COUNT;
            symbols_low_reg  <= RESET_SYMBOLS_LOW;
            symbols_high_reg <= RESET_SYMBOLS_HIGH;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SYMBOL_COUNT: symbol_count_reg <= cfg_data[COUNT_BITS-1:0];
                REG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_data;
                REG_SYMBOLS_HIGH: symbols_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < SYMBOL_SLOTS / 2; i++)
        begin
            sym[i]                    = symbols_low_reg[SYM_BITS*i +: SYM_BITS];
            sym[i + SYMBOL_SLOTS / 2] = symbols_high_reg[SYM_BITS*i +: SYM_BITS];
        end
    end

    // alphabet check: symbol idx against every later symbol in use
    assign cur_sym   = sym[idx_reg];
    assign count_bad = (symbol_count_reg < COUNT_BITS'(2)) ||
                       (symbol_count_reg > COUNT_BITS'(MAX_SYMBOLS));
    assign idx_at_end = ({1'b0, idx_reg} == symbol_count_reg - COUNT_BITS'(1));

    always_comb
    begin
        sym_bad = (cur_sym == CHAR_NUL) || (cur_sym == CHAR_PLUS) || (cur_sym == CHAR_MINUS);
        for (int j = 0; j < SYMBOL_SLOTS; j++)
        begin
            if ((COUNT_BITS'(j) > {1'b0, idx_reg}) && (COUNT_BITS'(j) < symbol_count_reg)
                && (sym[j] == cur_sym))
            begin
                sym_bad = 1'b1;
            end
        end
    end

    // magnitude at full width; the most negative value wraps to 2^(N-1) unsigned
    assign mag = value[VALUE_BITS-1] ? VALUE_BITS'(~value + 1'b1) : VALUE_BITS'(value);

    srt_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .load_mag (mag),
        .radix    (symbol_count_reg),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        sign_next      = sign_reg;
        nd_next        = nd_reg;
        push           = 1'b0;
        pop            = 1'b0;
        div_cmd        = '0;
        strobe_next    = 1'b0;
        character_next = character_reg;
        last_next      = last_reg;
        ok_next        = ok_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    div_cmd.load = 1'b1;
                    sign_next    = value[VALUE_BITS-1];
                    nd_next      = '0;
                    idx_next     = '0;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (count_bad || sym_bad)
                begin
                    strobe_next    = 1'b1;
                    character_next = CHAR_NUL;
                    last_next      = 1'b1;
                    ok_next        = 1'b0;
                    state_next     = ST_IDLE;
                end
                else if (idx_at_end)
                begin
                    div_cmd.go = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    idx_next = idx_reg + DIGIT_BITS'(1);
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    push    = 1'b1;
                    nd_next = nd_reg + ND_W'(1);
                    if (div_stat.quot_zero || (nd_reg == ND_W'(VALUE_BITS - 1)))
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        div_cmd.go = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                ok_next     = 1'b1;
                if (sign_reg)
                begin
                    character_next = CHAR_MINUS;
                    last_next      = 1'b0;
                    sign_next      = 1'b0;
                end
                else
                begin
                    character_next = sym[digit_reg[0]];
                    last_next      = (nd_reg == ND_W'(1));
                    pop            = 1'b1;
                    nd_next        = nd_reg - ND_W'(1);
                    if (nd_reg == ND_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            nd_reg     <= '0;
            idx_reg    <= '0;
            sign_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            nd_reg     <= nd_next;
            idx_reg    <= idx_next;
            sign_reg   <= sign_next;
        end
    end

    // digit stack: remainders arrive least significant first, top sits at entry 0
    always_ff @(posedge clk)
    begin
        character_reg <= character_next;
        last_reg      <= last_next;
        ok_reg        <= ok_next;
        if (push)
        begin
            digit_reg[0] <= div_stat.rem;
            for (int i = 1; i < VALUE_BITS; i++)
            begin
                digit_reg[i] <= digit_reg[i-1];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < VALUE_BITS - 1; i++)
            begin
                digit_reg[i] <= digit_reg[i+1];
            end
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign strobe      = strobe_reg;
    assign character   = character_reg;
    assign last        = last_reg;
    assign alphabet_ok = ok_reg;

    `SRT_ASSERT_IMP(a_invalid_is_last, strobe && !alphabet_ok, last && (character == CHAR_NUL))
    `SRT_ASSERT_IMP(a_emit_has_digits, state_reg == ST_EMIT, nd_reg != '0)
    `SRT_ASSERT_NXT(a_accept_to_check, start && !busy, state_reg == ST_CHECK)
    `SRT_ASSERT_IMP(a_done_only_in_div, div_stat.done, state_reg == ST_DIV)

endmodule

@@ rtl/core/srt_div.sv @@
// Digit-serial divider by a small radix (2..16): quotient replaces the dividend.
// Depends on srt_pkg and signed_radix_to_text_defines.svh.
`include "signed_radix_to_text_defines.svh"

module srt_div import srt_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_cmd_t              cmd,
    input  logic [VALUE_BITS-1:0] load_mag,
    input  logic [COUNT_BITS-1:0] radix,
    output div_stat_t             stat
);

    localparam int PAD_BITS = ((VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS)
                              * DIV_STEP_BITS;
    localparam int STEPS    = PAD_BITS / DIV_STEP_BITS;
    localparam int CNT_W    = $clog2(STEPS + 1);

    logic [PAD_BITS-1:0]      work_reg, work_next;
    logic [DIGIT_BITS-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     done_reg, done_next;

    // DIV_STEP_BITS restoring steps per cycle on a 4-bit remainder
    always_comb
    begin
        logic [DIGIT_BITS-1:0]    r;
        logic [DIGIT_BITS:0]      t;
        logic [DIV_STEP_BITS-1:0] q;
        r = rem_reg;
        q = '0;
        for (int k = 0; k < DIV_STEP_BITS; k++)
        begin
            t = {r, work_reg[PAD_BITS-1-k]};
            if (t >= radix)
            begin
                q[DIV_STEP_BITS-1-k] = 1'b1;
                r = DIGIT_BITS'(t - radix);
            end
            else
            begin
                r = t[DIGIT_BITS-1:0];
            end
        end

        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cmd.load)
        begin
            work_next = PAD_BITS'(load_mag);
        end
        else if (cmd.go)
        begin
            rem_next = '0;
            cnt_next = CNT_W'(STEPS);
        end
        else if (cnt_reg != '0)
        begin
            work_next = {work_reg[PAD_BITS-DIV_STEP_BITS-1:0], q};
            rem_next  = r;
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign stat.done      = done_reg;
    assign stat.quot_zero = (work_reg == '0);
    assign stat.rem       = rem_reg;

    `SRT_ASSERT_IMP(a_go_when_idle, cmd.go, cnt_reg == '0)
    `SRT_ASSERT_IMP(a_done_after_last, done_reg, $past(cnt_reg) == CNT_W'(1))
    `SRT_ASSERT_IMP(a_rem_below_radix, done_reg, {1'b0, rem_reg} < radix)

endmodule
